// File: src/flha_pkg.sv
`timescale 1ns / 1ps
package flha_pkg;

  // Arena geometry
  localparam int HEAP_UNITS = 4096;
  localparam int UNIT_BYTES = 16;
  localparam int AW         = 13;            // unit index width (0..HEAP_UNITS)
  localparam int BW         = 16;            // request byte count width

  // Byte-to-unit rounding: ceil division by UNIT_BYTES via reciprocal multiply
  localparam int XW    = BW + 1;             // bytes + UNIT_BYTES - 1
  localparam int UW    = XW;                 // unit count width
  localparam int UL    = $clog2(UNIT_BYTES);
  localparam int SH    = XW + UL;
  localparam int MW    = XW + 1;
  localparam int PW    = XW + MW;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + UNIT_BYTES - 1) / UNIT_BYTES);

  // Every list walk is bounded
  localparam int WALK_BOUND = 4 * (HEAP_UNITS + 2);
  localparam int SW         = $clog2(WALK_BOUND + 1);

  typedef logic [AW-1:0] addr_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_OOM  = 1'b1;

  // Request from the sequencer to the link/size stores
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  nx_we;
    addr_t nx_addr;
    addr_t nx_data;
    logic  sz_we;
    addr_t sz_addr;
    addr_t sz_data;
  } mem_req_t;

endpackage

// File: src/free_list_heap_allocator_unit.sv
`timescale 1ns / 1ps
// Free-list heap allocator over an arena of 4096 units of 16 bytes.
// Command channel: drive in_cmd (0 allocate, 1 free), in_request_bytes and
// in_block_address with start high; the beat is taken on a clock edge where
// busy is low. Each command yields exactly one result beat: out_valid is high
// for one cycle with out_address (allocated block, 0 on failure or free) and
// out_status (1 = out of memory). The receiver cannot stall; the result is
// registered and the next command may be issued in the same cycle.
// One command is in flight at a time. A free walks the list from the rover
// to its ordered slot; an allocate walks the list block by block, plus one
// release walk on the first wrap. Every step waits on one read of the
// link/size memories through their single read port, which sets the rate.
// Reset (synchronous, rst_n low) empties the list: the sentinel links to
// itself and the arena joins the list on the first allocate that wraps.
// Memory contents are not cleared; no entry is read before it is written, as long as only allocated blocks are freed.
module free_list_heap_allocator_unit
  import flha_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_cmd,
  input  logic [BW-1:0] in_request_bytes,
  input  logic [AW-1:0] in_block_address,
  output logic          out_valid,
  output logic [AW-1:0] out_address,
  output logic          out_status
);

  mem_req_t req;
  addr_t    rd_next;
  addr_t    rd_size;

  flha_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_request_bytes (in_request_bytes),
    .in_block_address (in_block_address),
    .out_valid        (out_valid),
    .out_address      (out_address),
    .out_status       (out_status),
    .req              (req),
    .rd_next          (rd_next),
    .rd_size          (rd_size)
  );

  flha_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_next (rd_next),
    .rd_size (rd_size)
  );

endmodule

// File: src/flha_mem.sv
`timescale 1ns / 1ps
module flha_mem
  import flha_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output addr_t    rd_next,
  output addr_t    rd_size
);

  // Link and size stores; entry 0 (sentinel) lives in a register
  addr_t next_mem [0:HEAP_UNITS];
  addr_t size_mem [0:HEAP_UNITS];

  addr_t next0_r;
  addr_t next_q_r;
  addr_t size_q_r;
  logic  sel_zero_r;
  logic  sel_oor_r;

  logic nx_in_range;
  logic sz_in_range;
  logic rd_in_range;

  assign nx_in_range = (req.nx_addr != '0) && (req.nx_addr <= AW'(HEAP_UNITS));
  assign sz_in_range = (req.sz_addr != '0) && (req.sz_addr <= AW'(HEAP_UNITS));
  assign rd_in_range = (req.rd_addr != '0) && (req.rd_addr <= AW'(HEAP_UNITS));

  // Sentinel link
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next0_r <= '0;
    end else if (req.nx_we && req.nx_addr == '0) begin
      next0_r <= req.nx_data;
    end
  end

  // Memory writes; out-of-arena writes are dropped
  always_ff @(posedge clk) begin
    if (req.nx_we && nx_in_range) begin
      next_mem[req.nx_addr] <= req.nx_data;
    end
    if (req.sz_we && sz_in_range) begin
      size_mem[req.sz_addr] <= req.sz_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (rd_in_range) begin
        next_q_r <= next_mem[req.rd_addr];
        size_q_r <= size_mem[req.rd_addr];
      end
      sel_zero_r <= (req.rd_addr == '0);
      sel_oor_r  <= !rd_in_range && (req.rd_addr != '0);
    end
  end

  // Sentinel has size zero; out-of-arena reads as zero
  always_comb begin
    if (sel_zero_r) begin
      rd_next = next0_r;
      rd_size = '0;
    end else if (sel_oor_r) begin
      rd_next = '0;
      rd_size = '0;
    end else begin
      rd_next = next_q_r;
      rd_size = size_q_r;
    end
  end

endmodule

// File: src/flha_ctrl.sv
`timescale 1ns / 1ps
module flha_ctrl
  import flha_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_cmd,
  input  logic [BW-1:0] in_request_bytes,
  input  addr_t         in_block_address,
  output logic          out_valid,
  output addr_t         out_address,
  output logic          out_status,
  output mem_req_t      req,
  input  addr_t         rd_next,
  input  addr_t         rd_size
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_UNITS, S_CHK, S_RDPREV, S_LOOP, S_SPLIT,
    S_RSTART, S_RWALK, S_RBP, S_RQ, S_RP
  } state_t;

  state_t         state_r, state_nxt;
  logic [XW-1:0]  x_r, x_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic [UW-1:0]  units_r, units_nxt;
  addr_t          prev_r, prev_nxt;
  addr_t          p_r, p_nxt;
  addr_t          rover_r, rover_nxt;
  logic           joined_r, joined_nxt;
  logic [SW-1:0]  steps_r, steps_nxt;
  logic [SW-1:0]  rsteps_r, rsteps_nxt;
  addr_t          bp_r, bp_nxt;
  addr_t          q_r, q_nxt;
  addr_t          sp_r, sp_nxt;
  addr_t          sb_r, sb_nxt;
  addr_t          nb_r, nb_nxt;
  addr_t          t_r, t_nxt;
  logic           ret_alloc_r, ret_alloc_nxt;
  logic           out_valid_r, out_valid_nxt;
  addr_t          out_address_r, out_address_nxt;
  logic           out_status_r, out_status_nxt;

  logic found;
  logic [AW:0] bp_end;
  logic [AW:0] p_end;

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_address = out_address_r;
  assign out_status  = out_status_r;

  // Address-ordered slot test during the release walk
  assign found  = ((bp_r > p_r) && (bp_r < rd_next)) ||
                  ((p_r >= rd_next) && ((bp_r > p_r) || (bp_r < rd_next)));
  assign bp_end = {1'b0, bp_r} + {1'b0, sb_r};
  assign p_end  = {1'b0, p_r} + {1'b0, sp_r};

  always_comb begin
    state_nxt       = state_r;
    x_nxt           = x_r;
    prod_nxt        = prod_r;
    units_nxt       = units_r;
    prev_nxt        = prev_r;
    p_nxt           = p_r;
    rover_nxt       = rover_r;
    joined_nxt      = joined_r;
    steps_nxt       = steps_r;
    rsteps_nxt      = rsteps_r;
    bp_nxt          = bp_r;
    q_nxt           = q_r;
    sp_nxt          = sp_r;
    sb_nxt          = sb_r;
    nb_nxt          = nb_r;
    t_nxt           = t_r;
    ret_alloc_nxt   = ret_alloc_r;
    out_valid_nxt   = 1'b0;
    out_address_nxt = out_address_r;
    out_status_nxt  = out_status_r;
    req             = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_ALLOC) begin
            x_nxt     = XW'(in_request_bytes) + XW'(UNIT_BYTES - 1);
            state_nxt = S_MUL;
          end else if (in_block_address == '0 ||
                       in_block_address > AW'(HEAP_UNITS)) begin
            out_valid_nxt   = 1'b1;
            out_address_nxt = '0;
            out_status_nxt  = ST_DONE;
          end else begin
            bp_nxt        = in_block_address;
            ret_alloc_nxt = 1'b0;
            state_nxt     = S_RSTART;
          end
        end
      end

      // Rounding: units = ceil(bytes / UNIT_BYTES) + 1
      S_MUL: begin
        prod_nxt  = PW'(x_r) * PW'(RECIP);
        state_nxt = S_UNITS;
      end

      S_UNITS: begin
        units_nxt = UW'(prod_r >> SH) + UW'(1);
        state_nxt = S_CHK;
      end

      S_CHK: begin
        if (units_r > UW'(HEAP_UNITS)) begin
          out_valid_nxt   = 1'b1;
          out_address_nxt = '0;
          out_status_nxt  = ST_OOM;
          state_nxt       = S_IDLE;
        end else begin
          prev_nxt    = rover_r;
          steps_nxt   = SW'(WALK_BOUND);
          req.rd_en   = 1'b1;
          req.rd_addr = rover_r;
          state_nxt   = S_RDPREV;
        end
      end

      // p = next(prev), then fetch p
      S_RDPREV: begin
        p_nxt       = rd_next;
        req.rd_en   = 1'b1;
        req.rd_addr = rd_next;
        state_nxt   = S_LOOP;
      end

      // Next-fit walk: size and link of p are on the read port
      S_LOOP: begin
        if (UW'(rd_size) >= units_r) begin
          rover_nxt = prev_r;
          if (UW'(rd_size) == units_r) begin
            req.nx_we       = 1'b1;
            req.nx_addr     = prev_r;
            req.nx_data     = rd_next;
            out_valid_nxt   = 1'b1;
            out_address_nxt = p_r;
            out_status_nxt  = (p_r == '0) ? ST_OOM : ST_DONE;
            state_nxt       = S_IDLE;
          end else begin
            req.sz_we   = 1'b1;
            req.sz_addr = p_r;
            req.sz_data = rd_size - AW'(units_r);
            t_nxt       = p_r + rd_size - AW'(units_r);
            state_nxt   = S_SPLIT;
          end
        end else if (p_r == rover_r) begin
          if (joined_r) begin
            out_valid_nxt   = 1'b1;
            out_address_nxt = '0;
            out_status_nxt  = ST_OOM;
            state_nxt       = S_IDLE;
          end else begin
            // first wrap: hand the whole arena to the list
            joined_nxt    = 1'b1;
            req.sz_we     = 1'b1;
            req.sz_addr   = AW'(1);
            req.sz_data   = AW'(HEAP_UNITS);
            bp_nxt        = AW'(1);
            ret_alloc_nxt = 1'b1;
            state_nxt     = S_RSTART;
          end
        end else if (steps_r == SW'(1)) begin
          out_valid_nxt   = 1'b1;
          out_address_nxt = '0;
          out_status_nxt  = ST_OOM;
          state_nxt       = S_IDLE;
        end else begin
          steps_nxt   = steps_r - SW'(1);
          prev_nxt    = p_r;
          p_nxt       = rd_next;
          req.rd_en   = 1'b1;
          req.rd_addr = rd_next;
        end
      end

      // Tail of a split block gets its header
      S_SPLIT: begin
        req.sz_we       = 1'b1;
        req.sz_addr     = t_r;
        req.sz_data     = AW'(units_r);
        out_valid_nxt   = 1'b1;
        out_address_nxt = t_r;
        out_status_nxt  = (t_r == '0) ? ST_OOM : ST_DONE;
        state_nxt       = S_IDLE;
      end

      // Release: walk from rover to the ordered slot
      S_RSTART: begin
        p_nxt       = rover_r;
        rsteps_nxt  = SW'(WALK_BOUND);
        req.rd_en   = 1'b1;
        req.rd_addr = rover_r;
        state_nxt   = S_RWALK;
      end

      S_RWALK: begin
        if (found) begin
          q_nxt       = rd_next;
          sp_nxt      = rd_size;
          req.rd_en   = 1'b1;
          req.rd_addr = bp_r;
          state_nxt   = S_RBP;
        end else if (rsteps_r == SW'(1)) begin
          // no slot: release fails
          out_valid_nxt   = 1'b1;
          out_address_nxt = '0;
          out_status_nxt  = ret_alloc_r ? ST_OOM : ST_DONE;
          state_nxt       = S_IDLE;
        end else begin
          rsteps_nxt  = rsteps_r - SW'(1);
          p_nxt       = rd_next;
          req.rd_en   = 1'b1;
          req.rd_addr = rd_next;
        end
      end

      S_RBP: begin
        sb_nxt      = rd_size;
        req.rd_en   = 1'b1;
        req.rd_addr = q_r;
        state_nxt   = S_RQ;
      end

      // Merge with upper neighbor
      S_RQ: begin
        req.nx_we   = 1'b1;
        req.nx_addr = bp_r;
        if (bp_end == {1'b0, q_r}) begin
          req.sz_we   = 1'b1;
          req.sz_addr = bp_r;
          req.sz_data = sb_r + rd_size;
          req.nx_data = rd_next;
          sb_nxt      = sb_r + rd_size;
          nb_nxt      = rd_next;
        end else begin
          req.nx_data = q_r;
          nb_nxt      = q_r;
        end
        state_nxt = S_RP;
      end

      // Merge with lower neighbor, then return
      S_RP: begin
        req.nx_we   = 1'b1;
        req.nx_addr = p_r;
        if (p_end == {1'b0, bp_r}) begin
          req.sz_we   = 1'b1;
          req.sz_addr = p_r;
          req.sz_data = sp_r + sb_r;
          req.nx_data = nb_r;
        end else begin
          req.nx_data = bp_r;
        end
        rover_nxt = p_r;
        if (!ret_alloc_r) begin
          out_valid_nxt   = 1'b1;
          out_address_nxt = '0;
          out_status_nxt  = ST_DONE;
          state_nxt       = S_IDLE;
        end else if (steps_r == SW'(1)) begin
          out_valid_nxt   = 1'b1;
          out_address_nxt = '0;
          out_status_nxt  = ST_OOM;
          state_nxt       = S_IDLE;
        end else begin
          // resume the walk from the new rover; its new link is forwarded
          steps_nxt   = steps_r - SW'(1);
          prev_nxt    = p_r;
          p_nxt       = req.nx_data;
          req.rd_en   = 1'b1;
          req.rd_addr = req.nx_data;
          state_nxt   = S_LOOP;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rover_r     <= '0;
      joined_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      joined_r    <= joined_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r           <= x_nxt;
    prod_r        <= prod_nxt;
    units_r       <= units_nxt;
    prev_r        <= prev_nxt;
    p_r           <= p_nxt;
    steps_r       <= steps_nxt;
    rsteps_r      <= rsteps_nxt;
    bp_r          <= bp_nxt;
    q_r           <= q_nxt;
    sp_r          <= sp_nxt;
    sb_r          <= sb_nxt;
    nb_r          <= nb_nxt;
    t_r           <= t_nxt;
    ret_alloc_r   <= ret_alloc_nxt;
    out_address_r <= out_address_nxt;
    out_status_r  <= out_status_nxt;
  end

endmodule
